/* hw/rtl/edu_pkg.sv */
// Shared types and constants for the Euclidean distance unit.
// No dependencies; edu_datapath, edu_ctrl and euclidean_distance_unit import this package.
package edu_pkg;

  localparam int unsigned ElemPortBits = 16;
  localparam int unsigned SumBits      = 40;
  localparam int unsigned DistBits     = 20;

  // Highest power of four that fits the sum: starting weight of the root search.
  localparam logic [SumBits-1:0] RootFirstBit = {2'b01, {(SumBits-2){1'b0}}};

  typedef struct packed {
    logic [ElemPortBits-1:0] query_element;
    logic [ElemPortBits-1:0] reference_element;
    logic                    last_element;
  } in_item_t;

  typedef struct packed {
    logic [DistBits-1:0] distance;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ACCUM,
    S_ROOT,
    S_DONE
  } edu_state_e;

  typedef struct packed {
    logic load_pair;
    logic square;
    logic accum;
    logic root_step;
    logic out_load;
  } edu_cmd_t;

  typedef struct packed {
    logic last;
    logic root_last;
  } edu_status_t;

endpackage

/* hw/rtl/edu_stream_if.sv */
// Valid/ready stream channel with a typed payload.
// Depends on nothing; payload types come from edu_pkg at the point of use.
interface edu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/edu_datapath.sv */
// Datapath: absolute difference, square, saturating accumulate and a
// bit-pair-per-cycle square root. Driven by edu_ctrl; uses edu_pkg.
module edu_datapath import edu_pkg::*; #(
  parameter int unsigned ElemBits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  edu_cmd_t            cmd_i,
  input  in_item_t            pair_i,
  output edu_status_t         status_o,
  output logic [DistBits-1:0] distance_o
);

  localparam int unsigned UsedBits = (ElemBits < ElemPortBits) ? ElemBits : ElemPortBits;
  localparam int unsigned SqBits   = 2 * UsedBits;

  logic [UsedBits-1:0] diff_q, diff_d;
  logic                last_q;
  logic [SqBits-1:0]   sq_q;
  logic [SumBits-1:0]  sum_q, sum_d;
  logic [SumBits-1:0]  rem_q, rem_d;
  logic [SumBits-1:0]  root_q, root_d;
  logic [SumBits-1:0]  bit_q, bit_d;
  logic [DistBits-1:0] dist_q;

  logic [UsedBits-1:0] q_el, r_el;
  logic [SumBits:0]    sum_wide;
  logic [SumBits-1:0]  sum_sat;
  logic [SumBits-1:0]  trial;

  assign q_el   = pair_i.query_element[UsedBits-1:0];
  assign r_el   = pair_i.reference_element[UsedBits-1:0];
  assign diff_d = (q_el >= r_el) ? (q_el - r_el) : (r_el - q_el);

  assign sum_wide = {1'b0, sum_q} + (SumBits + 1)'(sq_q);
  assign sum_sat  = sum_wide[SumBits] ? {SumBits{1'b1}} : sum_wide[SumBits-1:0];
  assign trial    = root_q + bit_q;

  always_comb begin
    sum_d  = sum_q;
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    if (cmd_i.accum) begin
      if (last_q) begin
        // Hand the final sum to the root search and start a fresh vector.
        sum_d  = '0;
        rem_d  = sum_sat;
        root_d = '0;
        bit_d  = RootFirstBit;
      end else begin
        sum_d = sum_sat;
      end
    end else if (cmd_i.root_step) begin
      if (rem_q >= trial) begin
        rem_d  = rem_q - trial;
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pair) begin
      diff_q <= diff_d;
      last_q <= pair_i.last_element;
    end
    if (cmd_i.square) begin
      sq_q <= SqBits'(diff_q) * SqBits'(diff_q);
    end
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    if (cmd_i.out_load) begin
      dist_q <= root_q[DistBits-1:0];
    end
  end

  assign status_o.last      = last_q;
  assign status_o.root_last = bit_q[0];
  assign distance_o         = dist_q;

  // A finished root always fits the distance field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> root_q[SumBits-1:DistBits] == '0)
    else $error("square root exceeds distance width");

  // Closing a vector leaves the running sum cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accum && last_q |=> sum_q == '0)
    else $error("sum not cleared after last element");

  // Within a vector the sum never drops (saturating add).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accum && !last_q |=> sum_q >= $past(sum_q))
    else $error("running sum decreased");

endmodule

/* hw/rtl/edu_ctrl.sv */
// Controller: sequences accept, square, accumulate, root steps and the
// output register handshake. Talks to edu_datapath through edu_pkg structs.
module edu_ctrl import edu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  edu_status_t status_i,
  output edu_cmd_t    cmd_o
);

  edu_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_SQUARE;
      S_SQUARE: state_d = S_ACCUM;
      S_ACCUM:  state_d = status_i.last ? S_ROOT : S_IDLE;
      S_ROOT:   if (status_i.root_last) state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_pair = in_valid_i;
      end
      S_SQUARE: cmd_o.square    = 1'b1;
      S_ACCUM:  cmd_o.accum     = 1'b1;
      S_ROOT:   cmd_o.root_step = 1'b1;
      S_DONE:   cmd_o.out_load  = out_free;
      default:  cmd_o           = '0;
    endcase
  end

  // Set on a new result, drop once the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A finished root with a free output register must show up at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && !out_valid_q |=> out_valid_q && state_q == S_IDLE)
    else $error("result not loaded into free output register");

  // An accepted transaction always goes on to be squared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_SQUARE)
    else $error("accepted pair not processed");

  // A pending result is never overwritten before the sink takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load && out_valid_q |-> out_ready_i)
    else $error("output register overwritten");

endmodule

/* hw/rtl/euclidean_distance_unit.sv */
// Euclidean distance unit: streams element pairs (16-bit unsigned, 6 fraction
// bits), sums squared differences in a 40-bit saturating register and, on the
// pair marked last, returns the floor square root of the sum as a 20-bit
// distance with 6 fraction bits, then clears the sum. The controller walks one
// pair at a time through the shared difference/multiplier/adder path: accept,
// square and accumulate, and for a pair marked last the square root, which
// resolves one root bit per cycle, and the load of the output register once the
// previous result has left it. No new pair is accepted before that walk ends.
// Only the low ELEMENT_BITS bits of each element are used.
// Depends on edu_pkg, edu_stream_if, edu_ctrl and edu_datapath.
module euclidean_distance_unit import edu_pkg::*; #(
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  edu_stream_if.sink     in_i,
  edu_stream_if.source   out_o
);

  edu_cmd_t            cmd;
  edu_status_t         status;
  in_item_t            pair;
  logic [DistBits-1:0] distance;

  assign pair = in_i.payload;

  edu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  edu_datapath #(
    .ElemBits (ELEMENT_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .pair_i     (pair),
    .status_o   (status),
    .distance_o (distance)
  );

  assign out_o.payload.distance = distance;

endmodule
